// File: design/lir_pkg.sv
// shared types, constants and defaults of the linear interpolation resampler
`timescale 1ns / 1ps

package lir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W = 24;
  localparam int POS_W = 25;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_INDEX_W = 2;

  localparam int DEF_MAX_OUTPUTS = 16;
  localparam int DEF_FRACTION_BITS = 16;

  // the fraction of the step times this must exceed one for interpolation
  localparam int BYPASS_SCALE = 1000;

  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEREO = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BIG_ENDIAN = 2'd3;

  // configuration reset values
  localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;
  localparam logic STEREO_RESET = 1'b1;
  localparam logic WIDE_RESET = 1'b1;
  localparam logic BIG_ENDIAN_RESET = 1'b0;

  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_q16;
    logic stereo;
    logic wide_samples;
    logic big_endian;
  } cfg_t;

  // one decoded frame on its way from the front to the back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] cur_l;
    logic signed [SAMPLE_W-1:0] cur_r;
    logic stereo;
    logic prime;
  } frame_t;

endpackage

// File: design/linear_interp_audio_resampler.sv
// top level of the linear interpolation audio resampler
`timescale 1ns / 1ps

// usage
// - in channel: one raw frame per transfer (byte0..byte3), in_valid / in_stall
// - out channel: left_sample, right_sample, last per transfer, out_valid / out_stall
// - config: cfg_write with cfg_index and cfg_data; step_q16, stereo, wide_samples,
//   big_endian; write only while no frame is in flight
// - the first frame after reset only primes the block and gives no result
// - a frame gives 0 to MAX_OUTPUTS_PER_FRAME results, the final one with last set
// - path: queue, position sequencer, issue stage, product stage, output register
// - throughput: one result per cycle while out_stall is low; the position sequencer
//   handles a frame in steps (pop, n issues, close), which sets the rate
// - a two-entry frame queue lets new frames come in while the back end works
// - out_stall with a result waiting freezes the whole interpolation pipeline; the queue then fills
//   and in_stall rises
// - reset (synchronous, active high) empties queue and pipeline, restores the
//   register defaults and clears the position and the primed state

module linear_interp_audio_resampler import lir_pkg::*; #(
  parameter int MAX_OUTPUTS_PER_FRAME = DEF_MAX_OUTPUTS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data
);

  cfg_t cfg;

  // front to queue
  logic push;
  logic full;
  frame_t push_data;

  // queue to back
  logic q_valid;
  logic pop;
  frame_t q_data;

  // configuration registers, plain writes with no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_q16 <= STEP_RESET;
      cfg.stereo <= STEREO_RESET;
      cfg.wide_samples <= WIDE_RESET;
      cfg.big_endian <= BIG_ENDIAN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STEP:       cfg.step_q16 <= cfg_data[STEP_W-1:0];
        CFG_STEREO:     cfg.stereo <= cfg_data[0];
        CFG_WIDE:       cfg.wide_samples <= cfg_data[0];
        CFG_BIG_ENDIAN: cfg.big_endian <= cfg_data[0];
      endcase
    end
  end

  // byte unpacking, q1.15 conversion and priming mark
  lir_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  // decouples frame intake from result generation
  lir_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop)
  );

  // position stepping and interpolation, one result per cycle while the output is not stalled
  lir_back #(
    .MAX_OUTPUTS_PER_FRAME (MAX_OUTPUTS_PER_FRAME),
    .FRACTION_BITS         (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: design/lir_front.sv
// front end: takes raw frames, converts them to q1.15 and marks the priming frame
`timescale 1ns / 1ps

module lir_front import lir_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     push,
  output frame_t   push_data,
  input  logic     full
);

  logic have_previous;
  logic signed [SAMPLE_W-1:0] left_q15;
  logic signed [SAMPLE_W-1:0] right_q15;

  assign in_stall = full;
  assign push = in_valid && !full;

  always_comb begin
    if (cfg.wide_samples) begin
      left_q15 = cfg.big_endian ? {in_data.byte0, in_data.byte1}
                                : {in_data.byte1, in_data.byte0};
      right_q15 = cfg.big_endian ? {in_data.byte2, in_data.byte3}
                                 : {in_data.byte3, in_data.byte2};
    end else begin
      // unsigned byte minus 128, moved to the top byte
      left_q15 = {~in_data.byte0[7], in_data.byte0[6:0], 8'h00};
      right_q15 = {~in_data.byte1[7], in_data.byte1[6:0], 8'h00};
    end
  end

  always_comb begin
    push_data.cur_l = left_q15;
    push_data.cur_r = cfg.stereo ? right_q15 : left_q15;
    push_data.stereo = cfg.stereo;
    push_data.prime = !have_previous;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
    end else if (push) begin
      have_previous <= 1'b1;
    end
  end

endmodule

// File: design/lir_queue.sv
// short frame queue between the front and the back
`timescale 1ns / 1ps

module lir_queue import lir_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_data,
  output logic   full,
  output logic   q_valid,
  output frame_t q_data,
  input  logic   pop
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FillW = $clog2(QUEUE_DEPTH + 1);

  frame_t slots [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [FillW-1:0] fill;

  assign full = (fill == FillW'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      unique case ({push, pop})
        2'b10: fill <= fill + FillW'(1);
        2'b01: fill <= fill - FillW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: design/lir_back.sv
// back end: position sequencer and interpolation pipeline with output register
`timescale 1ns / 1ps

module lir_back import lir_pkg::*; #(
  parameter int MAX_OUTPUTS_PER_FRAME = DEF_MAX_OUTPUTS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  frame_t    q_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CntW = $clog2(MAX_OUTPUTS_PER_FRAME + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_OUTPUTS_PER_FRAME);
  localparam logic [POS_W-1:0] PosOne = POS_W'(1) << FRACTION_BITS;
  localparam logic [POS_W:0] PosLimit = (POS_W + 1)'(PosOne) + ((POS_W + 1)'(1) << STEP_W);
  localparam int ScaleW = FRACTION_BITS + 10;
  localparam int ProdW = FRACTION_BITS + SAMPLE_W + 2;
  localparam logic signed [ProdW-1:0] Half = $signed(ProdW'(1) << (FRACTION_BITS - 1));

  // sequencer state
  logic busy;
  logic [CntW-1:0] count;
  logic [POS_W-1:0] pos;
  logic signed [SAMPLE_W-1:0] cur_l, cur_r, prev_l, prev_r;
  logic cur_stereo;

  // issue stage
  logic s1_valid;
  logic [FRACTION_BITS-1:0] s1_frac;
  logic signed [SAMPLE_W:0] s1_dl, s1_dr;
  logic signed [SAMPLE_W-1:0] s1_bl, s1_br;
  logic s1_stereo, s1_last;

  // product stage
  logic s2_valid;
  logic signed [ProdW-1:0] s2_pl, s2_pr;
  logic signed [SAMPLE_W-1:0] s2_bl, s2_br;
  logic s2_stereo, s2_last;

  logic en, more, issue, finish, issue_last, interpolate;
  logic [ScaleW-1:0] step_scaled;
  logic [POS_W-1:0] pos_step;
  logic [FRACTION_BITS-1:0] frac;
  logic signed [ProdW-1:0] sh_l, sh_r;
  logic signed [SAMPLE_W-1:0] res_l, res_r;

  // whole pipeline holds while a result waits on a stalled receiver
  assign en = !out_valid || !out_stall;

  assign step_scaled = ScaleW'(cfg.step_q16[FRACTION_BITS-1:0]) * ScaleW'(BYPASS_SCALE);
  assign interpolate = step_scaled > (ScaleW'(1) << FRACTION_BITS);

  assign more = (pos < PosOne) && (count < CntMax);
  assign issue = busy && more && en;
  assign finish = busy && !more;
  assign pos_step = pos + POS_W'(cfg.step_q16);
  assign issue_last = (pos_step >= PosOne) || (count + CntW'(1) == CntMax);
  assign frac = interpolate ? pos[FRACTION_BITS-1:0] : '0;
  assign pop = !busy && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
      pos <= '0;
      prev_l <= '0;
      prev_r <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (q_data.prime) begin
          prev_l <= q_data.cur_l;
          prev_r <= q_data.cur_r;
        end else begin
          busy <= 1'b1;
          count <= '0;
        end
      end else if (issue) begin
        pos <= pos_step;
        count <= count + CntW'(1);
      end else if (finish) begin
        if (pos >= PosOne) begin
          pos <= pos - PosOne;
        end
        prev_l <= cur_l;
        prev_r <= cur_r;
        busy <= 1'b0;
      end
      if (en) begin
        s1_valid <= issue;
        s2_valid <= s1_valid;
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_l <= q_data.cur_l;
      cur_r <= q_data.cur_r;
      cur_stereo <= q_data.stereo;
    end
  end

  assign sh_l = s2_pl >>> FRACTION_BITS;
  assign sh_r = s2_pr >>> FRACTION_BITS;
  assign res_l = s2_bl + sh_l[SAMPLE_W-1:0];
  assign res_r = s2_br + sh_r[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      // prev + round((cur - prev) * frac)
      s1_frac <= frac;
      s1_dl <= {cur_l[SAMPLE_W-1], cur_l} - {prev_l[SAMPLE_W-1], prev_l};
      s1_dr <= {cur_r[SAMPLE_W-1], cur_r} - {prev_r[SAMPLE_W-1], prev_r};
      s1_bl <= prev_l;
      s1_br <= prev_r;
      s1_stereo <= cur_stereo;
      s1_last <= issue_last;

      s2_pl <= s1_dl * $signed({1'b0, s1_frac}) + Half;
      s2_pr <= s1_dr * $signed({1'b0, s1_frac}) + Half;
      s2_bl <= s1_bl;
      s2_br <= s1_br;
      s2_stereo <= s1_stereo;
      s2_last <= s1_last;

      out_data.left_sample <= res_l;
      out_data.right_sample <= s2_stereo ? res_r : res_l;
      out_data.last <= s2_last;
    end
  end

  // the final result of a frame is never followed by another issue of that frame
  assert property (@(posedge clk) disable iff (rst) issue && issue_last |=> !issue)
    else $error("issue after the last result of a frame");

  // a frame always ends with a closing cycle after its last issue
  assert property (@(posedge clk) disable iff (rst) issue |=> busy)
    else $error("frame closed in the cycle of an issue");

  // position stays at or below one plus the largest step
  assert property (@(posedge clk) disable iff (rst) {1'b0, pos} < PosLimit)
    else $error("position out of range");

endmodule
